// ===== hw/rtl/i2c_bit_bang_byte_master_top_assert.svh =====
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef I2C_BIT_BANG_BYTE_MASTER_TOP_ASSERT_SVH
`define I2C_BIT_BANG_BYTE_MASTER_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define I2CBB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cbb same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define I2CBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cbb next-cycle check failed");

`endif

// ===== hw/rtl/i2cbb_pkg.sv =====
package i2cbb_pkg;

    localparam int HOLD_WIDTH = 16;
    localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = HOLD_WIDTH'(10);

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [5:0]            step;
        logic [HOLD_WIDTH-1:0] hold_count;
        logic [7:0]            shift_byte;
        logic                  ack_choice;
        logic                  scl;
        logic                  sda;
        logic                  sda_en;
        logic [7:0]            last_read;
    } state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       rejected;
    } res_t;

endpackage

// ===== hw/rtl/i2cbb_req_if.sv =====
interface i2cbb_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       ack_enable;
    logic       sda_in;

    modport source (output valid, action, data_byte, ack_enable, sda_in, input ready);
    modport sink (input valid, action, data_byte, ack_enable, sda_in, output ready);
endinterface

// ===== hw/rtl/i2cbb_rsp_if.sv =====
interface i2cbb_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                    read_data, rejected, input ready);
    modport sink (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                  read_data, rejected, output ready);
endinterface

// ===== hw/rtl/i2cbb_step.sv =====
module i2cbb_step (
    input  i2cbb_pkg::state_t                  cur,
    input  logic [2:0]                         action,
    input  logic [7:0]                         data_byte,
    input  logic                               ack_enable,
    input  logic                               sda_in,
    input  logic [i2cbb_pkg::HOLD_WIDTH-1:0]   hold_ticks,
    output i2cbb_pkg::state_t                  nxt,
    output i2cbb_pkg::res_t                    res
);

    // Applies the line changes made on entry to the current step.
    function automatic i2cbb_pkg::state_t enter_step(input i2cbb_pkg::state_t s_in);
        i2cbb_pkg::state_t s;
        logic [9:0]        prod;
        logic [5:0]        rem;
        logic [1:0]        ph;
        s    = s_in;
        // Step divided by three through a multiply by the reciprocal.
        prod = {4'b0, s.step} * 10'd11;
        rem  = s.step - {2'b0, prod[7:5], 1'b0} - {3'b0, prod[7:5]};
        ph   = rem[1:0];
        unique case (s.cmd)
            i2cbb_pkg::CMD_START:
            begin
                if (s.step == 6'd0)
                begin
                    s.scl = 1'b1;
                    s.sda = 1'b1;
                end
                else if (s.step == 6'd1)
                    s.sda = 1'b0;
                else
                    s.scl = 1'b0;
            end
            i2cbb_pkg::CMD_STOP:
            begin
                if (s.step == 6'd0)
                begin
                    s.sda = 1'b0;
                    s.scl = 1'b0;
                end
                else if (s.step == 6'd1)
                    s.scl = 1'b1;
                else
                    s.sda = 1'b1;
            end
            i2cbb_pkg::CMD_WRITE:
            begin
                if (s.step < 6'd24)
                begin
                    if (ph == 2'd0)
                        s.scl = 1'b0;
                    else if (ph == 2'd1)
                    begin
                        s.sda        = s.shift_byte[7];
                        s.shift_byte = {s.shift_byte[6:0], 1'b0};
                    end
                    else
                        s.scl = 1'b1;
                end
                else if (s.step == 6'd24)
                begin
                    s.scl = 1'b0;
                    if (s.ack_choice)
                        s.sda_en = 1'b0;
                    else
                    begin
                        s.sda    = 1'b1;
                        s.sda_en = 1'b1;
                    end
                end
                else if (s.step == 6'd26)
                    s.scl = 1'b1;
                else
                    s.scl = 1'b0;
            end
            i2cbb_pkg::CMD_READ:
            begin
                if (s.step < 6'd16)
                    s.scl = s.step[0];
                else if (s.step == 6'd16)
                begin
                    s.sda_en = 1'b1;
                    s.scl    = 1'b0;
                    s.sda    = !s.ack_choice;
                end
                else
                    s.scl = 1'b1;
            end
            default:
            begin
            end
        endcase
        return s;
    endfunction

    always_comb
    begin
        i2cbb_pkg::state_t                   s;
        logic                                cmd_ok;
        logic [i2cbb_pkg::HOLD_WIDTH-1:0]    limit;
        logic [i2cbb_pkg::HOLD_WIDTH-1:0]    dur;
        logic [i2cbb_pkg::HOLD_WIDTH:0]      hc_inc;
        logic [5:0]                          total;
        logic [5:0]                          step_inc;
        s      = cur;
        cmd_ok = (action >= i2cbb_pkg::CMD_START) && (action <= i2cbb_pkg::CMD_READ);
        limit  = (hold_ticks == '0) ? i2cbb_pkg::HOLD_WIDTH'(1) : hold_ticks;
        res    = '0;

        if (s.cmd != i2cbb_pkg::CMD_NONE)
            res.rejected = cmd_ok;
        else if (cmd_ok)
        begin
            s.cmd        = action;
            s.step       = '0;
            s.hold_count = '0;
            s.ack_choice = ack_enable;
            s.shift_byte = (action == i2cbb_pkg::CMD_WRITE) ? data_byte : 8'd0;
            if (action == i2cbb_pkg::CMD_READ)
                s.sda_en = 1'b0;
            s = enter_step(s);
        end

        res.scl_level  = s.scl;
        res.sda_level  = s.sda;
        res.sda_enable = s.sda_en;

        unique case (s.cmd)
            i2cbb_pkg::CMD_START, i2cbb_pkg::CMD_STOP: total = 6'd3;
            i2cbb_pkg::CMD_WRITE: total = s.ack_choice ? 6'd27 : 6'd28;
            i2cbb_pkg::CMD_READ:  total = 6'd18;
            default:              total = 6'd1;
        endcase
        dur = (s.cmd == i2cbb_pkg::CMD_READ && s.step == 6'd17)
            ? i2cbb_pkg::HOLD_WIDTH'(1) : limit;
        hc_inc   = {1'b0, s.hold_count} + (i2cbb_pkg::HOLD_WIDTH+1)'(1);
        step_inc = s.step + 6'd1;

        if (s.cmd != i2cbb_pkg::CMD_NONE)
        begin
            res.busy_res = 1'b1;
            if (hc_inc >= {1'b0, dur})
            begin
                if (s.cmd == i2cbb_pkg::CMD_READ && s.step < 6'd16 && s.step[0])
                    s.shift_byte = {s.shift_byte[6:0], sda_in};
                s.hold_count = '0;
                s.step       = step_inc;
                if (step_inc >= total)
                begin
                    if (s.cmd == i2cbb_pkg::CMD_WRITE && s.ack_choice)
                    begin
                        s.scl    = 1'b0;
                        s.sda_en = 1'b1;
                    end
                    if (s.cmd == i2cbb_pkg::CMD_READ)
                    begin
                        s.scl       = 1'b0;
                        s.last_read = s.shift_byte;
                    end
                    s.cmd        = i2cbb_pkg::CMD_NONE;
                    s.step       = '0;
                    res.done_res = 1'b1;
                end
                else
                    s = enter_step(s);
            end
            else
                s.hold_count = hc_inc[i2cbb_pkg::HOLD_WIDTH-1:0];
        end

        res.read_data = s.last_read;
        nxt           = s;
    end

endmodule

// ===== hw/rtl/i2cbb_out_stage.sv =====
module i2cbb_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  i2cbb_pkg::res_t    res,
    output logic               space,
    i2cbb_rsp_if.source        rsp
);

    logic            valid_reg;
    logic            valid_next;
    i2cbb_pkg::res_t data_reg;

    assign space      = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign rsp.valid      = valid_reg;
    assign rsp.scl_level  = data_reg.scl_level;
    assign rsp.sda_level  = data_reg.sda_level;
    assign rsp.sda_enable = data_reg.sda_enable;
    assign rsp.busy_res   = data_reg.busy_res;
    assign rsp.done_res   = data_reg.done_res;
    assign rsp.read_data  = data_reg.read_data;
    assign rsp.rejected   = data_reg.rejected;

endmodule

// ===== hw/rtl/i2c_bit_bang_byte_master_top.sv =====
// I2C bit-bang byte master, a line sequencer that advances by one tick per item.
// The req channel carries one tick per item: an action (none, start, stop, write
// byte, read byte), the byte to write, the ack choice and the sampled SDA level.
// The rsp channel returns one item per accepted tick with the SCL and SDA levels,
// the SDA drive enable, busy, done, the last read byte and a rejected flag.
// The cfg port writes hold_ticks, the ticks held per line step but a read's last;
// it should be written only while the sequencer is idle.
// An item is processed combinationally by the step logic and its result is shown
// on rsp in the cycle after acceptance; one item is accepted every cycle while
// rsp is taken.
// The output register sets the rate: req.ready is high when that register is
// empty or being read in the same cycle. When the receiver stalls, the result
// is held and req.ready drops until the result is taken.
// Reset leaves the sequencer idle with SCL high and SDA driven high, hold_ticks
// at ten, the read byte cleared and no result pending.
`include "i2c_bit_bang_byte_master_top_assert.svh"

module i2c_bit_bang_byte_master_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [i2cbb_pkg::HOLD_WIDTH-1:0]  cfg_wdata,
    i2cbb_req_if.sink                         req,
    i2cbb_rsp_if.source                       rsp
);

    i2cbb_pkg::state_t                 state_reg;
    i2cbb_pkg::state_t                 state_next;
    i2cbb_pkg::res_t                   res;
    logic [i2cbb_pkg::HOLD_WIDTH-1:0]  hold_reg;
    logic                              space;
    logic                              accept;

    assign req.ready = space;
    assign accept    = req.valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= i2cbb_pkg::HOLD_RESET;
        else if (cfg_we)
            hold_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{cmd: i2cbb_pkg::CMD_NONE, scl: 1'b1, sda: 1'b1, sda_en: 1'b1,
                           default: '0};
        else if (accept)
            state_reg <= state_next;
    end

    i2cbb_step u_step (
        .cur        (state_reg),
        .action     (req.action),
        .data_byte  (req.data_byte),
        .ack_enable (req.ack_enable),
        .sda_in     (req.sda_in),
        .hold_ticks (hold_reg),
        .nxt        (state_next),
        .res        (res)
    );

    i2cbb_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .res   (res),
        .space (space),
        .rsp   (rsp)
    );

    `I2CBB_ASSERT_NEXT(a_accept_gives_result, accept, rsp.valid)
    `I2CBB_ASSERT_SAME(a_done_while_busy, rsp.valid && rsp.done_res, rsp.busy_res)
    `I2CBB_ASSERT_SAME(a_reject_while_busy, rsp.valid && rsp.rejected, rsp.busy_res)
    `I2CBB_ASSERT_SAME(a_idle_step_zero, state_reg.cmd == i2cbb_pkg::CMD_NONE,
                       state_reg.step == 6'd0 && state_reg.sda_en)

endmodule

// ===== tb/i2cbb_line_checker.sv =====
module i2cbb_line_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cbb_pkg::HOLD_WIDTH-1:0] cfg_wdata,
    i2cbb_req_if                             req,
    i2cbb_rsp_if                             rsp,
    output int                               mismatches,
    output int                               pending,
    output int                               ticks_checked,
    output int                               seqs_done,
    output int                               rejects_seen
);

    logic [2:0]                       cur_cmd;
    logic [5:0]                       step_no;
    int unsigned                      held;
    logic [7:0]                       shreg;
    logic                             ack_sel;
    logic                             scl_q;
    logic                             sda_q;
    logic                             en_q;
    logic [7:0]                       last_byte;
    logic [i2cbb_pkg::HOLD_WIDTH-1:0] hold_cfg;

    i2cbb_pkg::res_t                  line_q[$];
    i2cbb_pkg::res_t                  want;
    i2cbb_pkg::res_t                  got;
    int                               err_cnt;
    int                               tick_cnt;
    int                               done_cnt;
    int                               rej_cnt;

    function automatic int unsigned hold_len();
        return (hold_cfg == '0) ? 1 : int'(hold_cfg);
    endfunction

    function automatic int unsigned steps_in_cmd();
        case (cur_cmd)
            i2cbb_pkg::CMD_START, i2cbb_pkg::CMD_STOP: return 3;
            i2cbb_pkg::CMD_WRITE:                      return ack_sel ? 27 : 28;
            i2cbb_pkg::CMD_READ:                       return 18;
            default:                                   return 1;
        endcase
    endfunction

    function automatic void enter_step();
        int ph;
        ph = int'(step_no) % 3;
        case (cur_cmd)
            i2cbb_pkg::CMD_START:
            begin
                if (step_no == 0)
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end
                else if (step_no == 1)
                    sda_q = 1'b0;
                else
                    scl_q = 1'b0;
            end
            i2cbb_pkg::CMD_STOP:
            begin
                if (step_no == 0)
                begin
                    sda_q = 1'b0;
                    scl_q = 1'b0;
                end
                else if (step_no == 1)
                    scl_q = 1'b1;
                else
                    sda_q = 1'b1;
            end
            i2cbb_pkg::CMD_WRITE:
            begin
                if (step_no < 24)
                begin
                    if (ph == 0)
                        scl_q = 1'b0;
                    else if (ph == 1)
                    begin
                        sda_q = shreg[7];
                        shreg = {shreg[6:0], 1'b0};
                    end
                    else
                        scl_q = 1'b1;
                end
                else if (step_no == 24)
                begin
                    scl_q = 1'b0;
                    if (ack_sel)
                        en_q = 1'b0;
                    else
                    begin
                        sda_q = 1'b1;
                        en_q = 1'b1;
                    end
                end
                else if (step_no == 26)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end
            i2cbb_pkg::CMD_READ:
            begin
                if (step_no < 16)
                    scl_q = step_no[0];
                else if (step_no == 16)
                begin
                    en_q = 1'b1;
                    scl_q = 1'b0;
                    sda_q = ~ack_sel;
                end
                else
                    scl_q = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic i2cbb_pkg::res_t next_tick(input logic [2:0] act,
                                                  input logic [7:0] dat,
                                                  input logic ack, input logic sda);
        i2cbb_pkg::res_t r;
        logic            is_cmd;
        int unsigned     dur;
        r = '0;
        is_cmd = (act >= i2cbb_pkg::CMD_START) && (act <= i2cbb_pkg::CMD_READ);
        if (cur_cmd != i2cbb_pkg::CMD_NONE)
            r.rejected = is_cmd;
        else if (is_cmd)
        begin
            cur_cmd = act;
            step_no = '0;
            held = 0;
            ack_sel = ack;
            shreg = (act == i2cbb_pkg::CMD_WRITE) ? dat : 8'h00;
            if (act == i2cbb_pkg::CMD_READ)
                en_q = 1'b0;
            enter_step();
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_enable = en_q;
        if (cur_cmd != i2cbb_pkg::CMD_NONE)
        begin
            r.busy_res = 1'b1;
            held++;
            dur = (cur_cmd == i2cbb_pkg::CMD_READ && step_no == 17) ? 1 : hold_len();
            if (held >= dur)
            begin
                if (cur_cmd == i2cbb_pkg::CMD_READ && step_no < 16 && step_no[0])
                    shreg = {shreg[6:0], sda};
                held = 0;
                step_no = step_no + 6'd1;
                if (step_no >= steps_in_cmd())
                begin
                    if (cur_cmd == i2cbb_pkg::CMD_WRITE && ack_sel)
                    begin
                        scl_q = 1'b0;
                        en_q = 1'b1;
                    end
                    if (cur_cmd == i2cbb_pkg::CMD_READ)
                    begin
                        scl_q = 1'b0;
                        last_byte = shreg;
                    end
                    cur_cmd = i2cbb_pkg::CMD_NONE;
                    step_no = '0;
                    held = 0;
                    r.done_res = 1'b1;
                end
                else
                    enter_step();
            end
        end
        r.read_data = last_byte;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_cmd = i2cbb_pkg::CMD_NONE;
            step_no = '0;
            held = 0;
            shreg = '0;
            ack_sel = 1'b0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            en_q = 1'b1;
            last_byte = '0;
            hold_cfg = i2cbb_pkg::HOLD_RESET;
            line_q.delete();
            err_cnt = 0;
            tick_cnt = 0;
            done_cnt = 0;
            rej_cnt = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.scl_level = rsp.scl_level;
                got.sda_level = rsp.sda_level;
                got.sda_enable = rsp.sda_enable;
                got.busy_res = rsp.busy_res;
                got.done_res = rsp.done_res;
                got.read_data = rsp.read_data;
                got.rejected = rsp.rejected;
                if (line_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("Result item arrived with no tick waiting for it");
                end
                else
                begin
                    want = line_q.pop_front();
                    tick_cnt++;
                    if (got !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"Tick %0d mismatch: expected scl %b sda %b en %b ",
                                      "busy %b done %b byte %h rej %b, got scl %b sda %b ",
                                      "en %b busy %b done %b byte %h rej %b"},
                                     tick_cnt, want.scl_level, want.sda_level,
                                     want.sda_enable, want.busy_res, want.done_res,
                                     want.read_data, want.rejected, got.scl_level,
                                     got.sda_level, got.sda_enable, got.busy_res,
                                     got.done_res, got.read_data, got.rejected);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want = next_tick(req.action, req.data_byte, req.ack_enable, req.sda_in);
                line_q.push_back(want);
                if (want.done_res)
                    done_cnt++;
                if (want.rejected)
                    rej_cnt++;
            end
            if (cfg_we)
                hold_cfg = cfg_wdata;
        end
        mismatches <= err_cnt;
        pending <= line_q.size();
        ticks_checked <= tick_cnt;
        seqs_done <= done_cnt;
        rejects_seen <= rej_cnt;
    end

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [i2cbb_pkg::HOLD_WIDTH-1:0] cfg_wdata;

    int                               src_idle_pct;
    int                               rsp_stall_pct;
    int unsigned                      hold_now;
    int                               cycle_count;
    int unsigned                      seg_hold[6] = '{2, 0, 3, 1, 5, 1};

    int                               mismatches;
    int                               pending;
    int                               ticks_checked;
    int                               seqs_done;
    int                               rejects_seen;

    i2cbb_req_if req_ch();
    i2cbb_rsp_if rsp_ch();

    i2c_bit_bang_byte_master_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    i2cbb_line_checker line_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .mismatches    (mismatches),
        .pending       (pending),
        .ticks_checked (ticks_checked),
        .seqs_done     (seqs_done),
        .rejects_seen  (rejects_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    function automatic int unsigned cmd_ticks(input logic [2:0] act, input logic ack);
        int unsigned h;
        h = (hold_now == 0) ? 1 : hold_now;
        case (act)
            i2cbb_pkg::CMD_START, i2cbb_pkg::CMD_STOP: return 3 * h;
            i2cbb_pkg::CMD_WRITE:                      return ack ? 27 * h : 28 * h;
            i2cbb_pkg::CMD_READ:                       return 17 * h + 1;
            default:                                   return 1;
        endcase
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [7:0] dat,
                             input logic ack, input logic sda);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.data_byte <= dat;
        req_ch.ack_enable <= ack;
        req_ch.sda_in <= sda;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_hold(input logic [i2cbb_pkg::HOLD_WIDTH-1:0] v);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        hold_now = 32'(v);
    endtask

    task automatic run_command(input logic [2:0] act, input logic [7:0] dat, input logic ack,
                               input logic sda, input logic [2:0] mid_act,
                               input logic [2:0] last_act);
        int unsigned total;
        total = cmd_ticks(act, ack);
        send_item(act, dat, ack, sda);
        for (int unsigned k = 1; k < total; k++)
            send_item((k == total - 1) ? last_act
                      : ((k == 1) ? mid_act : i2cbb_pkg::CMD_NONE),
                      dat, ack, sda);
    endtask

    task automatic random_ticks(input int count);
        int          sent;
        int unsigned left;
        logic [2:0]  act;
        logic        ack;
        sent = 0;
        left = 0;
        while (sent < count || left != 0)
        begin
            ack = 1'($urandom_range(1));
            if (left == 0)
            begin
                if ($urandom_range(4) != 0)
                begin
                    act = 3'($urandom_range(i2cbb_pkg::CMD_READ, i2cbb_pkg::CMD_START));
                    left = cmd_ticks(act, ack) - 1;
                end
                else
                    act = ($urandom_range(3) == 0) ? i2cbb_pkg::CMD_NONE
                                                   : 3'($urandom_range(7, 5));
            end
            else
            begin
                left--;
                act = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 1))
                                               : i2cbb_pkg::CMD_NONE;
            end
            send_item(act, 8'($urandom_range(255)), ack, 1'($urandom_range(1)));
            sent++;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.action <= i2cbb_pkg::CMD_NONE;
        req_ch.data_byte <= '0;
        req_ch.ack_enable <= 1'b0;
        req_ch.sda_in <= 1'b0;
        src_idle_pct = 10;
        rsp_stall_pct = 57;
        hold_now = 32'(i2cbb_pkg::HOLD_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first start runs at the reset hold; the rest of the directed part uses a hold of one.
        run_command(i2cbb_pkg::CMD_START, 8'h00, 1'b0, 1'b0, i2cbb_pkg::CMD_NONE,
                    i2cbb_pkg::CMD_NONE);
        set_hold(i2cbb_pkg::HOLD_WIDTH'(1));
        run_command(i2cbb_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0, i2cbb_pkg::CMD_NONE,
                    i2cbb_pkg::CMD_NONE);
        run_command(i2cbb_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b1, i2cbb_pkg::CMD_READ, 3'd5);
        run_command(i2cbb_pkg::CMD_READ, 8'h00, 1'b1, 1'b1, i2cbb_pkg::CMD_NONE,
                    i2cbb_pkg::CMD_WRITE);
        run_command(i2cbb_pkg::CMD_READ, 8'hFF, 1'b0, 1'b0, i2cbb_pkg::CMD_STOP,
                    i2cbb_pkg::CMD_NONE);
        run_command(i2cbb_pkg::CMD_WRITE, 8'hA5, 1'b1, 1'b0, i2cbb_pkg::CMD_NONE,
                    i2cbb_pkg::CMD_START);
        run_command(i2cbb_pkg::CMD_STOP, 8'h5A, 1'b0, 1'b1, i2cbb_pkg::CMD_NONE,
                    i2cbb_pkg::CMD_STOP);
        send_item(3'd5, 8'hFF, 1'b1, 1'b1);
        send_item(3'd6, 8'hFF, 1'b1, 1'b1);
        send_item(3'd7, 8'hFF, 1'b1, 1'b1);
        send_item(i2cbb_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);

        for (int seg = 0; seg < 6; seg++)
        begin
            src_idle_pct = (seg < 2) ? 10 : ((seg < 4) ? 57 : 0);
            rsp_stall_pct = (seg < 2) ? 57 : ((seg < 4) ? 10 : 0);
            set_hold(i2cbb_pkg::HOLD_WIDTH'(seg_hold[seg]));
            random_ticks(260);
        end

        // At the widest hold only the opening of a stop sequence is run.
        set_hold('1);
        send_item(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
        for (int k = 0; k < 40; k++)
            send_item((k == 20) ? i2cbb_pkg::CMD_START : i2cbb_pkg::CMD_NONE,
                      8'h00, 1'b0, 1'b0);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Checked %0d line ticks: %0d finished sequences and %0d rejected commands.",
                 ticks_checked, seqs_done, rejects_seen);
        $display("Hold settings ran from zero up to a short stretch at the 16-bit maximum.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/i2cbb_pkg.sv
hw/rtl/i2cbb_req_if.sv
hw/rtl/i2cbb_rsp_if.sv
hw/rtl/i2cbb_step.sv
hw/rtl/i2cbb_out_stage.sv
hw/rtl/i2c_bit_bang_byte_master_top.sv
tb/i2cbb_line_checker.sv
tb/tb.sv
